### hw/rtl/assert_macros.svh
// assertion macros used by the hash table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define AST_NEVER(lbl, cond, msg) \
	`AST_PROP(lbl, !(cond), msg)
`else
`define AST_PROP(lbl, prop, msg)
`define AST_NEVER(lbl, cond, msg)
`endif

`endif

### hw/rtl/ohash_pkg.sv
// shared types and constants of the open addressing hash table
package ohash_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int VAL_W    = 64;
	localparam int CFG_W    = 9;
	localparam int CMP_W    = CNT_W + CFG_W;
	localparam int KSLOT_W  = KEY_W + 1;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(192);

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_SET = 2'd1,
		OP_INS = 2'd2,
		OP_DEL = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_REFUSED   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		SK_HIT,
		SK_EMPTY,
		SK_TOMB,
		SK_NONE
	} slot_kind_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic early;
		logic stop;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/ohash_ram.sv
// generic single write port ram with registered read
module ohash_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/ohash_ctrl.sv
// controller state machine of the hash table
module ohash_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ohash_pkg::dp_stat_t stat,
	output ohash_pkg::dp_cmd_t  cmd
);

	ohash_pkg::state_t state_q;
	ohash_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohash_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ohash_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = stat.early ? ohash_pkg::S_DONE : ohash_pkg::S_PROBE;
				end
			end
			ohash_pkg::S_PROBE: begin
				if (stat.stop) begin
					cmd.commit = 1'b1;
					state_nxt  = ohash_pkg::S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ohash_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.push  = 1'b1;
					state_nxt = ohash_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ohash_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/ohash_dp.sv
// datapath of the hash table: slot stores, probe registers, result and output registers
`include "assert_macros.svh"

module ohash_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ohash_pkg::dp_cmd_t             cmd,
	output ohash_pkg::dp_stat_t            stat,
	input  logic                           cfg_wr_en,
	input  logic [ohash_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic [1:0]                     opcode,
	input  logic [ohash_pkg::KEY_W-1:0]    key_id,
	input  logic [ohash_pkg::HASH_W-1:0]   key_hash,
	input  logic [ohash_pkg::VAL_W-1:0]    value_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic                           was_new_key,
	output logic [ohash_pkg::VAL_W-1:0]    value_out
);

	logic [ohash_pkg::CFG_W-1:0]    max_q;
	logic [ohash_pkg::CNT_W-1:0]    count_q;
	ohash_pkg::opcode_t             op_q;
	logic [ohash_pkg::KEY_W-1:0]    key_q;
	logic [ohash_pkg::VAL_W-1:0]    val_q;
	logic [ohash_pkg::IDX_W-1:0]    idx_q;
	logic [ohash_pkg::IDX_W-1:0]    n_q;
	logic [ohash_pkg::IDX_W-1:0]    tomb_q;
	logic                           tomb_seen_q;
	logic [ohash_pkg::CAPACITY-1:0] slot_valid_q;
	logic                           valid_s1;
	ohash_pkg::status_t             res_status_q;
	logic                           res_new_q;
	logic [ohash_pkg::VAL_W-1:0]    res_val_q;
	logic                           out_valid_q;
	ohash_pkg::status_t             out_status_q;
	logic                           out_new_q;
	logic [ohash_pkg::VAL_W-1:0]    out_val_q;

	ohash_pkg::opcode_t             op_in;
	logic                           is_read_in;
	logic                           load_full;
	logic                           early;
	ohash_pkg::status_t             early_status;
	logic [ohash_pkg::IDX_W-1:0]    rd_addr;
	logic [ohash_pkg::KSLOT_W-1:0]  kram_rdata;
	logic [ohash_pkg::VAL_W-1:0]    vram_rdata;
	logic [ohash_pkg::KEY_W-1:0]    cur_key;
	logic                           cur_tomb;
	logic                           hit;
	logic                           empty_slot;
	logic                           tomb_slot;
	logic                           last;
	ohash_pkg::slot_kind_t          kind;
	logic [ohash_pkg::IDX_W-1:0]    slot;
	ohash_pkg::status_t             c_status;
	logic                           c_new;
	logic [ohash_pkg::VAL_W-1:0]    c_val;
	logic                           k_wr;
	logic                           v_wr;
	logic                           k_we;
	logic                           v_we;
	logic [ohash_pkg::KSLOT_W-1:0]  k_wdata;
	logic                           cnt_inc;

	// early decisions taken on the incoming item
	assign op_in      = ohash_pkg::opcode_t'(opcode);
	assign is_read_in = (op_in == ohash_pkg::OP_GET) || (op_in == ohash_pkg::OP_DEL);
	assign load_full  = (ohash_pkg::CMP_W'(count_q) + ohash_pkg::CMP_W'(1)) >
	                    ohash_pkg::CMP_W'(max_q);

	always_comb begin
		if (is_read_in) begin
			early        = (key_id == '0) || (count_q == '0);
			early_status = ohash_pkg::ST_NOT_FOUND;
		end else begin
			early        = (key_id == '0) || load_full;
			early_status = (key_id == '0) ? ohash_pkg::ST_REFUSED : ohash_pkg::ST_FULL;
		end
	end

	assign stat.early = early;

	// probe reads run one slot ahead of the check
	assign rd_addr = cmd.load ? key_hash[ohash_pkg::IDX_W-1:0] : idx_q + ohash_pkg::IDX_W'(1);

	ohash_ram #(
		.WIDTH (ohash_pkg::KSLOT_W),
		.DEPTH (ohash_pkg::CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (slot),
		.wdata (k_wdata),
		.raddr (rd_addr),
		.rdata (kram_rdata)
	);

	ohash_ram #(
		.WIDTH (ohash_pkg::VAL_W),
		.DEPTH (ohash_pkg::CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (slot),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (vram_rdata)
	);

	assign cur_key    = valid_s1 ? kram_rdata[ohash_pkg::KEY_W-1:0] : '0;
	assign cur_tomb   = valid_s1 & kram_rdata[ohash_pkg::KEY_W];
	assign hit        = (cur_key != '0) && (cur_key == key_q);
	assign empty_slot = (cur_key == '0) && !cur_tomb;
	assign tomb_slot  = (cur_key == '0) && cur_tomb;
	assign last       = (n_q == '1);
	assign stat.stop  = hit || empty_slot || last;

	// chosen slot once the probe stops
	always_comb begin
		kind = ohash_pkg::SK_NONE;
		slot = idx_q;
		if (hit) begin
			kind = ohash_pkg::SK_HIT;
		end else if (tomb_seen_q) begin
			kind = ohash_pkg::SK_TOMB;
			slot = tomb_q;
		end else if (empty_slot) begin
			kind = ohash_pkg::SK_EMPTY;
		end else if (tomb_slot) begin
			kind = ohash_pkg::SK_TOMB;
		end
	end

	always_comb begin
		c_status = ohash_pkg::ST_OK;
		c_new    = 1'b0;
		c_val    = '0;
		k_wr     = 1'b0;
		v_wr     = 1'b0;
		k_wdata  = {1'b0, key_q};
		case (op_q)
			ohash_pkg::OP_GET: begin
				if (hit) begin
					c_val = vram_rdata;
				end else begin
					c_status = ohash_pkg::ST_NOT_FOUND;
				end
			end
			ohash_pkg::OP_DEL: begin
				if (hit) begin
					k_wr    = 1'b1;
					k_wdata = {1'b1, {ohash_pkg::KEY_W{1'b0}}};
				end else begin
					c_status = ohash_pkg::ST_NOT_FOUND;
				end
			end
			ohash_pkg::OP_SET: begin
				if (kind == ohash_pkg::SK_NONE) begin
					c_status = ohash_pkg::ST_FULL;
				end else begin
					k_wr  = 1'b1;
					v_wr  = 1'b1;
					c_new = (kind != ohash_pkg::SK_HIT);
				end
			end
			ohash_pkg::OP_INS: begin
				if (kind == ohash_pkg::SK_EMPTY) begin
					k_wr  = 1'b1;
					v_wr  = 1'b1;
					c_new = 1'b1;
				end else if (kind == ohash_pkg::SK_NONE) begin
					c_status = ohash_pkg::ST_FULL;
				end else begin
					c_status = ohash_pkg::ST_REFUSED;
				end
			end
			default: begin
				c_status = ohash_pkg::ST_OK;
			end
		endcase
	end

	assign k_we    = cmd.commit && k_wr;
	assign v_we    = cmd.commit && v_wr;
	assign cnt_inc = k_we && (kind == ohash_pkg::SK_EMPTY);

	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= ohash_pkg::MAX_ENTRIES_RST;
			count_q      <= '0;
			slot_valid_q <= '0;
			tomb_seen_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (cnt_inc) begin
				count_q <= count_q + ohash_pkg::CNT_W'(1);
			end
			if (k_we) begin
				slot_valid_q[slot] <= 1'b1;
			end
			if (cmd.load) begin
				tomb_seen_q <= 1'b0;
			end else if (cmd.step && tomb_slot) begin
				tomb_seen_q <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		valid_s1 <= slot_valid_q[rd_addr];
		if (cmd.load) begin
			op_q  <= op_in;
			key_q <= key_id;
			val_q <= value_in;
			idx_q <= key_hash[ohash_pkg::IDX_W-1:0];
			n_q   <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + ohash_pkg::IDX_W'(1);
			n_q   <= n_q + ohash_pkg::IDX_W'(1);
		end
		if (cmd.step && tomb_slot && !tomb_seen_q) begin
			tomb_q <= idx_q;
		end
		if (cmd.load && early) begin
			res_status_q <= early_status;
			res_new_q    <= 1'b0;
			res_val_q    <= '0;
		end else if (cmd.commit) begin
			res_status_q <= c_status;
			res_new_q    <= c_new;
			res_val_q    <= c_val;
		end
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_new_q    <= res_new_q;
			out_val_q    <= res_val_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign was_new_key = out_new_q;
	assign value_out   = out_val_q;

	`AST_PROP(a_push_free, cmd.push |-> stat.out_free, "result pushed into a busy output register")
	`AST_PROP(a_step_bound, cmd.step |-> !last, "probe stepped past the last slot")
	`AST_PROP(a_count_step, (count_q != $past(count_q)) |-> $past(cnt_inc), "count moved alone")
	`AST_NEVER(a_count_cap, count_q > ohash_pkg::CNT_W'(ohash_pkg::CAPACITY), "count above capacity")

endmodule

### hw/rtl/open_addressing_hash_table_unit.sv
// result: k slots probed (k = 1 to 256), then committed to the result register and pushed out
// early answers (reserved key, empty table on a read, load limit on a write) skip the probe
// a new item waits until the last is pushed; the single read port probe checks one slot a cycle
// output register holds a finished result while the next item is taken
// reset: all slots read empty at once through per-slot valid flops, count 0, max_entries 192
// slot values are undefined until written
module open_addressing_hash_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [ohash_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [ohash_pkg::KEY_W-1:0]  key_id,
	input  logic [ohash_pkg::HASH_W-1:0] key_hash,
	input  logic [ohash_pkg::VAL_W-1:0]  value_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         was_new_key,
	output logic [ohash_pkg::VAL_W-1:0]  value_out
);

	ohash_pkg::dp_cmd_t  cmd;
	ohash_pkg::dp_stat_t stat;

	ohash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ohash_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.key_id      (key_id),
		.key_hash    (key_hash),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.was_new_key (was_new_key),
		.value_out   (value_out)
	);

endmodule
